// ----- design/ffha_pkg.sv -----
package ffha_pkg;

   localparam int ADDR_BITS   = 32;
   localparam int REQ_SIZE_W  = 15;
   localparam int STATUS_W    = 2;
   localparam int WORDS_W     = 14;
   localparam int NEED_W      = 16;
   localparam int HDR_BYTES   = 8;

   // Header tags stand for the in-use and freed signatures of a software heap.
   typedef enum logic [1:0] {
      TAG_NONE  = 2'd0,
      TAG_USED  = 2'd1,
      TAG_FREED = 2'd2
   } tag_type;

   typedef struct packed {
      tag_type              tag;
      logic [WORDS_W-1:0]   words;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic {
      KIND_ALLOC   = 1'b0,
      KIND_RELEASE = 1'b1
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ALLOCATED = 2'd0,
      STATUS_RELEASED  = 2'd1,
      STATUS_NO_MEMORY = 2'd2,
      STATUS_IGNORED   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_APPEND,
      ST_RELEASE,
      ST_DONE
   } state_type;

endpackage

// ----- design/ffha_if.sv -----
interface ffha_req_if;
   logic                              valid;
   logic                              ready;
   logic                              kind;
   logic [ffha_pkg::REQ_SIZE_W-1:0]   request_size;
   logic [ffha_pkg::ADDR_BITS-1:0]    release_address;

   modport source (output valid, output kind, output request_size,
                   output release_address, input ready);
   modport sink   (input valid, input kind, input request_size,
                   input release_address, output ready);
endinterface

interface ffha_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ffha_pkg::ADDR_BITS-1:0]    payload_address;
   logic [ffha_pkg::STATUS_W-1:0]     status;

   modport source (output valid, output payload_address, output status, input ready);
   modport sink   (input valid, input payload_address, input status, output ready);
endinterface

interface ffha_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ffha_pkg::ADDR_BITS-1:0]    heap_base;

   modport source (output valid, output heap_base, input ready);
   modport sink   (input valid, input heap_base, output ready);
endinterface

// ----- design/first_fit_heap_allocator.sv -----
// First-fit heap allocator: block headers live in one RAM of HEAP_BYTES/4 entries.
// Allocate: the walk reads the headers in order, one per cycle on the single RAM read port,
// and on no fit appends a new block at the heap end. Release: reads the header, then frees it.
// One item is in work at a time; the result register lets the next item enter early.
// Reset (synchronous) clears the control registers, then a clearing pass writes every
// header entry (HEAP_BYTES/4, 4096 by default) before the first item.
module first_fit_heap_allocator #(
   parameter int HEAP_BYTES = 16384
) (
   input logic       clock,
   input logic       reset,
   ffha_req_if.sink   req_chan,
   ffha_rsp_if.source rsp_chan,
   ffha_csr_if.sink   csr_chan
);

   import ffha_pkg::*;

   localparam int DEPTH = HEAP_BYTES / 4;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int OFF_W = $clog2(HEAP_BYTES + 1);
   localparam int SUM_W = ((OFF_W > NEED_W) ? OFF_W : NEED_W) + 2;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       clear_cnt_ff;
   logic [OFF_W-1:0]       heap_end_ff;
   logic [OFF_W-1:0]       off_ff;
   logic [WORDS_W-1:0]     words_ff;
   logic [IDX_W-1:0]       rel_idx_ff;
   logic [ADDR_BITS-1:0]   heap_base_ff;
   logic [ADDR_BITS-1:0]   res_addr_ff;
   status_type             res_status_ff;
   logic                   rsp_valid_ff;
   logic [ADDR_BITS-1:0]   rsp_addr_ff;
   status_type             rsp_status_ff;

   logic                   mem_wr_en;
   logic [IDX_W-1:0]       mem_wr_addr;
   entry_type              mem_wr_data;
   logic                   mem_rd_en;
   logic [IDX_W-1:0]       mem_rd_addr;
   logic [ENTRY_W-1:0]     mem_rd_data;

   logic                   req_fire;
   logic                   is_release;
   logic [NEED_W-1:0]      need_sum;
   logic [WORDS_W-1:0]     req_words;
   logic [ADDR_BITS-1:0]   rel_off;
   logic                   rel_bad;
   entry_type              rd_entry;
   logic                   fit;
   logic [SUM_W-1:0]       walk_next;
   logic                   walk_more;
   logic [SUM_W-1:0]       append_end;
   logic                   no_room;
   logic                   rsp_free;

   ffha_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_header_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign is_release     = (req_chan.kind == KIND_RELEASE);

   // Round the request up to whole 4-byte words.
   assign need_sum  = NEED_W'(req_chan.request_size) + NEED_W'(3);
   assign req_words = need_sum[NEED_W-1:2];

   assign rel_off = req_chan.release_address - heap_base_ff - ADDR_BITS'(HDR_BYTES);
   assign rel_bad = (req_chan.release_address == '0) || (rel_off[1:0] != 2'b00) ||
                    (rel_off >= ADDR_BITS'(HEAP_BYTES));

   assign rd_entry   = entry_type'(mem_rd_data);
   assign fit        = (rd_entry.tag == TAG_FREED) && (rd_entry.words >= words_ff);
   assign walk_next  = SUM_W'(off_ff) + SUM_W'(HDR_BYTES) + SUM_W'({rd_entry.words, 2'b00});
   assign walk_more  = (walk_next < SUM_W'(heap_end_ff));
   assign append_end = SUM_W'(heap_end_ff) + SUM_W'(HDR_BYTES) + SUM_W'({words_ff, 2'b00});
   assign no_room    = (append_end > SUM_W'(HEAP_BYTES));
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_cnt_ff == IDX_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (is_release) begin
                  state_in = rel_bad ? ST_DONE : ST_RELEASE;
               end else begin
                  state_in = (heap_end_ff == '0) ? ST_APPEND : ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (fit) begin
               state_in = ST_DONE;
            end else if (!walk_more) begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND:  state_in = ST_DONE;
         ST_RELEASE: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '{tag: TAG_NONE, words: '0};
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clear_cnt_ff;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (is_release) begin
                  mem_rd_en   = !rel_bad;
                  mem_rd_addr = rel_off[IDX_W+1:2];
               end else begin
                  // The walk always starts at the first header.
                  mem_rd_en = (heap_end_ff != '0);
               end
            end
         end
         ST_WALK: begin
            if (fit) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = off_ff[IDX_W+1:2];
               mem_wr_data = '{tag: TAG_USED, words: rd_entry.words};
            end else if (walk_more) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = walk_next[IDX_W+1:2];
            end
         end
         ST_APPEND: begin
            if (!no_room) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = heap_end_ff[IDX_W+1:2];
               mem_wr_data = '{tag: TAG_USED, words: words_ff};
            end
         end
         ST_RELEASE: begin
            if (rd_entry.tag == TAG_USED) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = rel_idx_ff;
               mem_wr_data = '{tag: TAG_FREED, words: rd_entry.words};
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         heap_end_ff  <= '0;
         heap_base_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clear_cnt_ff <= clear_cnt_ff + IDX_W'(1);
         end
         if (csr_chan.valid) begin
            heap_base_ff <= csr_chan.heap_base;
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  words_ff      <= req_words;
                  off_ff        <= '0;
                  rel_idx_ff    <= rel_off[IDX_W+1:2];
                  res_addr_ff   <= '0;
                  res_status_ff <= STATUS_IGNORED;
               end
            end
            ST_WALK: begin
               if (fit) begin
                  res_addr_ff   <= heap_base_ff + ADDR_BITS'(off_ff) + ADDR_BITS'(HDR_BYTES);
                  res_status_ff <= STATUS_ALLOCATED;
               end else begin
                  off_ff <= walk_next[OFF_W-1:0];
               end
            end
            ST_APPEND: begin
               if (no_room) begin
                  res_status_ff <= STATUS_NO_MEMORY;
               end else begin
                  res_addr_ff   <= heap_base_ff + ADDR_BITS'(heap_end_ff) +
                                   ADDR_BITS'(HDR_BYTES);
                  res_status_ff <= STATUS_ALLOCATED;
                  heap_end_ff   <= append_end[OFF_W-1:0];
               end
            end
            ST_RELEASE: begin
               if (rd_entry.tag == TAG_USED) begin
                  res_status_ff <= STATUS_RELEASED;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_addr_ff   <= res_addr_ff;
                  rsp_status_ff <= res_status_ff;
               end
            end
            ST_CLEAR: begin
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.payload_address = rsp_addr_ff;
   assign rsp_chan.status          = rsp_status_ff;

   a_end_bounded: assert property (@(posedge clock) disable iff (reset)
      heap_end_ff <= OFF_W'(HEAP_BYTES))
      else $error("heap end beyond heap size");

   a_end_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (heap_end_ff >= $past(heap_end_ff)) && (heap_end_ff[1:0] == 2'b00))
      else $error("heap end shrank or lost word alignment");

   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("header write and read in the same cycle");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result issued outside the done state");

endmodule

// ----- design/ffha_ram.sv -----
module ffha_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/sv/heap_result_checker.sv -----
`timescale 1ns / 100ps

module heap_result_checker #(
   parameter int HEAP_BYTES = 16384
) (
   input  logic clock,
   input  logic reset,
   ffha_req_if  req_chan,
   ffha_rsp_if  rsp_chan,
   ffha_csr_if  csr_chan,
   output int   mismatch_count,
   output int   pending_results
);

   import ffha_pkg::*;

   localparam int SLOTS = HEAP_BYTES / 4;
   localparam int IDX_W = $clog2(SLOTS);

   typedef struct packed {
      logic [ADDR_BITS-1:0] address;
      status_type           status;
   } outcome_type;

   entry_type            header_copy [SLOTS];
   logic [ADDR_BITS-1:0] base_addr;
   int unsigned          end_offset;
   outcome_type          expected_outcomes [$];

   function automatic void note_mismatch(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s: expected 0x%08h, got 0x%08h", $time, what, want, got);
      end
   endfunction

   // Works out the result of one item and updates the copy of the header store.
   function automatic outcome_type predict_outcome(input logic kind,
                                                   input logic [REQ_SIZE_W-1:0] req_bytes,
                                                   input logic [ADDR_BITS-1:0] address);
      logic [16:0]          need;
      logic [WORDS_W-1:0]   words;
      logic [ADDR_BITS-1:0] offset;
      int unsigned          walk;
      entry_type            hdr;
      outcome_type          outcome;

      outcome.address = '0;
      if (kind == KIND_RELEASE) begin
         outcome.status = STATUS_IGNORED;
         offset = address - base_addr - 32'(HDR_BYTES);
         if (address != '0 && offset[1:0] == 2'b00 && offset < 32'(HEAP_BYTES)) begin
            if (header_copy[offset[IDX_W+1:2]].tag == TAG_USED) begin
               header_copy[offset[IDX_W+1:2]].tag = TAG_FREED;
               outcome.status = STATUS_RELEASED;
            end
         end
         return outcome;
      end

      need  = (17'(req_bytes) + 17'd3) & ~17'd3;
      words = need[15:2];
      walk  = 0;
      while (walk < end_offset) begin
         hdr = header_copy[walk[IDX_W+1:2]];
         if (hdr.tag == TAG_FREED && hdr.words >= words) begin
            // A freed block is reused whole, never split.
            header_copy[walk[IDX_W+1:2]].tag = TAG_USED;
            outcome.status  = STATUS_ALLOCATED;
            outcome.address = base_addr + 32'(walk) + 32'(HDR_BYTES);
            return outcome;
         end
         walk += HDR_BYTES + (int'(hdr.words) << 2);
      end

      if (end_offset + HDR_BYTES + int'(need) > HEAP_BYTES) begin
         outcome.status = STATUS_NO_MEMORY;
         return outcome;
      end
      header_copy[end_offset[IDX_W+1:2]] = '{tag: TAG_USED, words: words};
      outcome.status  = STATUS_ALLOCATED;
      outcome.address = base_addr + 32'(end_offset) + 32'(HDR_BYTES);
      end_offset += HDR_BYTES + int'(need);
      return outcome;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            header_copy[IDX_W'(i)] = '{tag: TAG_NONE, words: '0};
         end
         end_offset = 0;
         base_addr  = '0;
         expected_outcomes.delete();
         pending_results = 0;
         mismatch_count  = 0;
      end else begin
         // A result never leaves at the edge its own item enters, so the check comes first.
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_outcomes.size() == 0) begin
               note_mismatch("result with none expected", '0, rsp_chan.payload_address);
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_chan.status !== want.status) begin
                  note_mismatch("status", 32'(want.status), 32'(rsp_chan.status));
               end
               if (rsp_chan.payload_address !== want.address) begin
                  note_mismatch("payload_address", want.address, rsp_chan.payload_address);
               end
            end
         end
         if (csr_chan.valid && csr_chan.ready) begin
            base_addr = csr_chan.heap_base;
         end
         if (req_chan.valid && req_chan.ready) begin
            expected_outcomes.push_back(predict_outcome(req_chan.kind, req_chan.request_size,
                                                        req_chan.release_address));
         end
         pending_results = expected_outcomes.size();
      end
   end

endmodule

// ----- tb/sv/first_fit_heap_allocator_tb.sv -----
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;
   import ffha_pkg::*;

   localparam int HEAP_BYTES = 16384;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ffha_req_if req_chan ();
   ffha_rsp_if rsp_chan ();
   ffha_csr_if csr_chan ();

   int mismatch_count;
   int pending_results;

   bit                   calm = 1'b0;
   bit                   hold_request = 1'b0;
   logic [ADDR_BITS-1:0] base_now = '0;
   logic [ADDR_BITS-1:0] last_release_offset = 32'd8;
   logic [ADDR_BITS-1:0] live_offsets [$];

   first_fit_heap_allocator #(.HEAP_BYTES(HEAP_BYTES)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   heap_result_checker #(.HEAP_BYTES(HEAP_BYTES)) watch (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .csr_chan        (csr_chan),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Handshakes are stable between rising edges, so an allocation seen here is one
   // that the next edge accepts. Its offset is kept for later releases.
   always @(negedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready && rsp_chan.status == STATUS_ALLOCATED) begin
         live_offsets.push_back(rsp_chan.payload_address - base_now);
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            for (int n = 0; n < 400; n++) begin
               @(posedge clock);
            end
         end else begin
            rsp_chan.ready <= calm || $urandom_range(99) >= 7;
         end
      end
   end

   task automatic send_item(input kind_type kind, input logic [REQ_SIZE_W-1:0] req_bytes,
                            input logic [ADDR_BITS-1:0] address);
      if (!calm && $urandom_range(99) < 7) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.kind            <= kind;
      req_chan.request_size    <= req_bytes;
      req_chan.release_address <= address;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_for_results();
      do @(negedge clock); while (pending_results != 0);
      @(posedge clock);
   endtask

   task automatic write_heap_base(input logic [ADDR_BITS-1:0] value);
      csr_chan.valid     <= 1'b1;
      csr_chan.heap_base <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      base_now = value;
   endtask

   task automatic send_random_item();
      int unsigned          pick;
      int unsigned          slot;
      int unsigned          spread;
      logic [REQ_SIZE_W-1:0] req_bytes;
      logic [ADDR_BITS-1:0] address;

      pick = $urandom_range(99);
      if (pick < 55 || (pick < 90 && live_offsets.size() == 0)) begin
         // Mostly small blocks, so that many headers build up; large ones mostly run
         // out of memory.
         spread = $urandom_range(99);
         if (spread < 10) begin
            req_bytes = REQ_SIZE_W'($urandom_range(8));
         end else if (spread < 75) begin
            req_bytes = REQ_SIZE_W'($urandom_range(120, 9));
         end else if (spread < 95) begin
            req_bytes = REQ_SIZE_W'($urandom_range(600, 121));
         end else if (spread < 98) begin
            req_bytes = REQ_SIZE_W'($urandom_range(4096, 601));
         end else begin
            req_bytes = REQ_SIZE_W'($urandom_range(HEAP_BYTES, 4097));
         end
         send_item(KIND_ALLOC, req_bytes, $urandom());
      end else if (pick < 90) begin
         slot = $urandom_range(live_offsets.size() - 1);
         last_release_offset = live_offsets[slot];
         live_offsets.delete(slot);
         send_item(KIND_RELEASE, REQ_SIZE_W'($urandom_range(HEAP_BYTES)),
                   base_now + last_release_offset);
      end else begin
         case ($urandom_range(4))
            0: address = '0;
            1: address = $urandom();
            2: address = base_now + 32'(HDR_BYTES + HEAP_BYTES) + ($urandom_range(3) << 2);
            3: address = base_now + 32'(HDR_BYTES) + ($urandom_range(HEAP_BYTES / 4 - 1) << 2)
                         + $urandom_range(3);
            default: address = base_now + last_release_offset;
         endcase
         send_item(KIND_RELEASE, REQ_SIZE_W'($urandom_range(HEAP_BYTES)), address);
      end
   endtask

   task automatic run_phase(input logic [ADDR_BITS-1:0] new_base, input int count,
                            input bit quiet, input bit squeeze);
      wait_for_results();
      write_heap_base(new_base);
      calm = quiet;
      if (squeeze) begin
         hold_request = 1'b1;
      end
      repeat (count) send_random_item();
      req_chan.valid <= 1'b0;
   endtask

   initial begin
      int waited;

      req_chan.valid           = 1'b0;
      req_chan.kind            = KIND_ALLOC;
      req_chan.request_size    = '0;
      req_chan.release_address = '0;
      csr_chan.valid           = 1'b0;
      csr_chan.heap_base       = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // The base lands while the block is still clearing its header store.
      write_heap_base(32'h0000_1000);
      send_item(KIND_RELEASE, '0, '0);
      send_item(KIND_RELEASE, '0, base_now + 32'd8);
      send_item(KIND_ALLOC, 15'd0, '0);
      send_item(KIND_ALLOC, 15'd1, '0);
      send_item(KIND_ALLOC, 15'd3, '0);
      send_item(KIND_ALLOC, 15'd4, '0);
      send_item(KIND_ALLOC, 15'd5, '0);
      send_item(KIND_ALLOC, 15'(HEAP_BYTES), '0);
      send_item(KIND_ALLOC, 15'(HEAP_BYTES - 7), '0);
      send_item(KIND_RELEASE, '0, base_now + 32'd16);
      send_item(KIND_RELEASE, '0, base_now + 32'd16);
      // The freed one-word block is too small here, so a new block is appended.
      send_item(KIND_ALLOC, 15'd8, '0);
      send_item(KIND_ALLOC, 15'd2, '0);
      send_item(KIND_RELEASE, '0, base_now + 32'd18);
      send_item(KIND_RELEASE, '0, base_now + 32'(HDR_BYTES + HEAP_BYTES));
      send_item(KIND_RELEASE, '0, base_now + 32'd20);
      send_item(KIND_RELEASE, '0, base_now + 32'd8);
      send_item(KIND_ALLOC, 15'd0, '0);
      send_item(KIND_RELEASE, '0, 32'hFFFF_FFFF);
      send_item(KIND_RELEASE, '0, base_now + 32'd40);
      send_item(KIND_RELEASE, '0, base_now + 32'd28);
      send_item(KIND_ALLOC, 15'd4, '0);
      send_item(KIND_RELEASE, 15'(HEAP_BYTES), base_now + 32'd52);
      send_item(KIND_ALLOC, 15'd4, 32'hFFFF_FFFF);
      req_chan.valid <= 1'b0;

      run_phase(32'h0000_0000, 238, 1'b0, 1'b0);
      // With this base the first block's payload sits at address zero.
      run_phase(32'hFFFF_FFF8, 238, 1'b0, 1'b1);
      run_phase(32'hFFFF_FFFF, 238, 1'b1, 1'b0);
      run_phase($urandom(), 238, 1'b0, 1'b0);
      run_phase(32'h8000_0000, 238, 1'b0, 1'b1);
      run_phase($urandom(), 238, 1'b0, 1'b0);

      for (waited = 0; waited < 20000 && pending_results != 0; waited++) begin
         @(negedge clock);
      end
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("first_fit_heap_allocator_tb OK");
      end else begin
         $display("first_fit_heap_allocator_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #150_000_000;
      $display("first_fit_heap_allocator_tb NOT OK");
      $finish;
   end

endmodule

// ----- sim.f -----
design/ffha_pkg.sv
design/ffha_if.sv
design/ffha_ram.sv
design/first_fit_heap_allocator.sv
tb/sv/heap_result_checker.sv
tb/sv/first_fit_heap_allocator_tb.sv
